### hw/rtl/dual_pid_drive_controller_defines.svh
// Assertion macros shared by the dual PID drive controller RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DUAL_PID_DRIVE_CONTROLLER_DEFINES_SVH
`define DUAL_PID_DRIVE_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DPID_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpid assertion failed");

// next-cycle implication, disabled during reset
`define DPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpid assertion failed");

`endif

### hw/rtl/dpid_pkg.sv
// Shared types and constants for the dual PID drive controller.
// No dependencies; imported by dpid_loop, dual_pid_drive_controller and the bench.
package dpid_pkg;

    localparam int WHEEL_COUNT         = 6;
    localparam int POSITION_BITS       = 24;
    localparam int HEADING_BITS        = 24;
    localparam int TARGET_HEADING_BITS = 20;
    localparam int HEADING_FRAC_BITS   = 4;
    localparam int GAIN_BITS           = 32;
    localparam int LIMIT_BITS          = 7;
    localparam int DRIVE_BITS          = 16;
    localparam int POWER_BITS          = 32;
    localparam int TOTAL_BITS          = 48;
    localparam int CFG_INDEX_BITS      = 3;
    localparam int CFG_DATA_BITS       = 32;

    // wheel sum and divide-by-wheel-count via exact reciprocal multiply
    localparam int SUM_BITS       = POSITION_BITS + $clog2(WHEEL_COUNT);
    localparam int DIV_SHIFT      = SUM_BITS + $clog2(WHEEL_COUNT);
    localparam int DIV_RECIP_BITS = SUM_BITS + 2;
    localparam logic [DIV_RECIP_BITS-1:0] DIV_RECIP = DIV_RECIP_BITS'(
        ((64'd1 << DIV_SHIFT) + 64'(WHEEL_COUNT - 1)) / 64'(WHEEL_COUNT));

    localparam int MERR_BITS = POSITION_BITS + 1;
    localparam int TERR_BITS = HEADING_BITS + 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVE_KP = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVE_KD = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MOVE_KS = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_KP = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_KD = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TURN_KS = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LIMIT   = 3'd6;

    localparam logic [GAIN_BITS-1:0]  RST_MOVE_KP = 32'd2348810;
    localparam logic [GAIN_BITS-1:0]  RST_MOVE_KD = 32'd0;
    localparam logic [GAIN_BITS-1:0]  RST_MOVE_KS = 32'd336;
    localparam logic [GAIN_BITS-1:0]  RST_TURN_KP = 32'd8891924;
    localparam logic [GAIN_BITS-1:0]  RST_TURN_KD = 32'd0;
    localparam logic [GAIN_BITS-1:0]  RST_TURN_KS = 32'd1426;
    localparam logic [LIMIT_BITS-1:0] RST_LIMIT   = 7'd80;

    typedef struct packed {
        logic signed [POSITION_BITS-1:0]       wheel_left_front;
        logic signed [POSITION_BITS-1:0]       wheel_left_mid;
        logic signed [POSITION_BITS-1:0]       wheel_left_back;
        logic signed [POSITION_BITS-1:0]       wheel_right_front;
        logic signed [POSITION_BITS-1:0]       wheel_right_mid;
        logic signed [POSITION_BITS-1:0]       wheel_right_back;
        logic signed [HEADING_BITS-1:0]        heading_now;
        logic signed [POSITION_BITS-1:0]       target_distance;
        logic signed [TARGET_HEADING_BITS-1:0] target_heading;
    } t_dpid_in;

    typedef struct packed {
        logic signed [DRIVE_BITS-1:0] left_drive;
        logic signed [DRIVE_BITS-1:0] right_drive;
        logic signed [POWER_BITS-1:0] move_power;
        logic signed [POWER_BITS-1:0] turn_power;
    } t_dpid_out;

    // stage advance strobes for the loop datapath
    typedef struct packed {
        logic prod;
        logic acc;
        logic scale;
    } t_loop_adv;

endpackage

### hw/rtl/dual_pid_drive_controller.sv
// Dual PID drive controller: wheel averaging, error tracking and side drive clamp.
// Depends on dpid_pkg, dpid_loop and dual_pid_drive_controller_defines.svh.

// Takes one sensor sample per clock while the input is not stalled and returns one drive result per sample.
// The result passes through every stage below before it is presented, and a
// stalled output only stalls the input once every stage holds an item. The only
// recurrence is the error total and last-error update in stage three, a single
// add and saturate, so a new sample may follow in every cycle. Stages: input
// register, wheel divide by reciprocal multiply, error and state update, gain
// products, wide sum, truncate and saturate, side clamp into the output register.
// Write gains and limit only while no sample is in flight: the gains are read
// in stage four and the limit in stage seven.
`include "dual_pid_drive_controller_defines.svh"

module dual_pid_drive_controller
    import dpid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  t_dpid_in                  i_in,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output t_dpid_out                 o_out,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data
);

    localparam int STAGES   = 7;
    localparam int ST_IN    = 0;
    localparam int ST_DIV   = 1;
    localparam int ST_ERR   = 2;
    localparam int ST_PROD  = 3;
    localparam int ST_ACC   = 4;
    localparam int ST_SCALE = 5;
    localparam int ST_OUT   = 6;

    function automatic logic signed [TOTAL_BITS-1:0] sat_total(
        input logic signed [TOTAL_BITS:0] s
    );
        if (s[TOTAL_BITS] != s[TOTAL_BITS-1]) begin
            return s[TOTAL_BITS] ? {1'b1, {(TOTAL_BITS-1){1'b0}}}
                                 : {1'b0, {(TOTAL_BITS-1){1'b1}}};
        end
        return s[TOTAL_BITS-1:0];
    endfunction

    function automatic logic signed [DRIVE_BITS-1:0] side_clamp(
        input logic signed [POWER_BITS:0]  s,
        input logic        [LIMIT_BITS-1:0] lim
    );
        logic signed [POWER_BITS:0] lim_ext;
        lim_ext = {{(POWER_BITS+1-LIMIT_BITS){1'b0}}, lim};
        if (s > lim_ext) begin
            return DRIVE_BITS'(lim);
        end
        if (s[POWER_BITS] && !(&s[POWER_BITS-1:DRIVE_BITS-1])) begin
            return {1'b1, {(DRIVE_BITS-1){1'b0}}};
        end
        return s[DRIVE_BITS-1:0];
    endfunction

    // configuration
    logic [GAIN_BITS-1:0]  r_move_kp, r_move_kd, r_move_ks;
    logic [GAIN_BITS-1:0]  r_turn_kp, r_turn_kd, r_turn_ks;
    logic [LIMIT_BITS-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_kp <= RST_MOVE_KP;
            r_move_kd <= RST_MOVE_KD;
            r_move_ks <= RST_MOVE_KS;
            r_turn_kp <= RST_TURN_KP;
            r_turn_kd <= RST_TURN_KD;
            r_turn_ks <= RST_TURN_KS;
            r_limit   <= RST_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MOVE_KP: r_move_kp <= i_cfg_data[GAIN_BITS-1:0];
                CFG_MOVE_KD: r_move_kd <= i_cfg_data[GAIN_BITS-1:0];
                CFG_MOVE_KS: r_move_ks <= i_cfg_data[GAIN_BITS-1:0];
                CFG_TURN_KP: r_turn_kp <= i_cfg_data[GAIN_BITS-1:0];
                CFG_TURN_KD: r_turn_kd <= i_cfg_data[GAIN_BITS-1:0];
                CFG_TURN_KS: r_turn_ks <= i_cfg_data[GAIN_BITS-1:0];
                CFG_LIMIT:   r_limit   <= i_cfg_data[LIMIT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline flow control: a stage loads when it is empty or drains
    logic [STAGES-1:0] r_vld, n_vld, rdy;

    always_comb begin
        rdy[STAGES-1] = !r_vld[STAGES-1] || !i_out_stall;
        for (int k = STAGES-2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign n_vld = {r_vld[STAGES-2:0], i_in_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_in_stall  = !rdy[ST_IN];
    assign o_out_valid = r_vld[ST_OUT];

    // stage 1: wheel sum and heading error
    logic signed [POSITION_BITS-1:0] wheel [WHEEL_COUNT];
    logic signed [SUM_BITS-1:0]      n_sum, r1_sum;
    logic signed [TERR_BITS-1:0]     n_terr, r1_terr;
    logic signed [POSITION_BITS-1:0] r1_tgt;

    assign wheel[0] = i_in.wheel_left_front;
    assign wheel[1] = i_in.wheel_left_mid;
    assign wheel[2] = i_in.wheel_left_back;
    assign wheel[3] = i_in.wheel_right_front;
    assign wheel[4] = i_in.wheel_right_mid;
    assign wheel[5] = i_in.wheel_right_back;

    always_comb begin
        n_sum = '0;
        for (int k = 0; k < WHEEL_COUNT; k++) begin
            n_sum = n_sum + SUM_BITS'(wheel[k]);
        end
    end

    assign n_terr = (TERR_BITS'(i_in.target_heading) <<< HEADING_FRAC_BITS)
                  - TERR_BITS'(i_in.heading_now);

    always_ff @(posedge i_clk) begin
        if (rdy[ST_IN]) begin
            r1_sum  <= n_sum;
            r1_terr <= n_terr;
            r1_tgt  <= i_in.target_distance;
        end
    end

    // stage 2: magnitude times reciprocal, sign kept aside
    logic [SUM_BITS-1:0]                n_mag;
    logic [SUM_BITS+DIV_RECIP_BITS-1:0] n_prod;
    logic [POSITION_BITS-1:0]           r2_quot;
    logic                               r2_neg;
    logic signed [POSITION_BITS-1:0]    r2_tgt;
    logic signed [TERR_BITS-1:0]        r2_terr;

    assign n_mag  = r1_sum[SUM_BITS-1] ? SUM_BITS'(-r1_sum) : SUM_BITS'(r1_sum);
    assign n_prod = n_mag * DIV_RECIP;

    always_ff @(posedge i_clk) begin
        if (rdy[ST_DIV]) begin
            r2_quot <= n_prod[DIV_SHIFT +: POSITION_BITS];
            r2_neg  <= r1_sum[SUM_BITS-1];
            r2_tgt  <= r1_tgt;
            r2_terr <= r1_terr;
        end
    end

    // stage 3: errors, differences and saturating totals (loop state)
    logic                            upd;
    logic signed [MERR_BITS-1:0]     n_merr, r_last_merr;
    logic signed [MERR_BITS:0]       n_mdiff, r3_mdiff;
    logic signed [TOTAL_BITS:0]      n_msum;
    logic signed [TOTAL_BITS-1:0]    r_move_tot;
    logic signed [TERR_BITS-1:0]     r_last_terr;
    logic signed [TERR_BITS:0]       n_tdiff, r3_tdiff;
    logic signed [TOTAL_BITS:0]      n_tsum;
    logic signed [TOTAL_BITS-1:0]    r_turn_tot;

    assign upd = rdy[ST_ERR] && r_vld[ST_DIV];

    // target minus signed quotient; the sign flips subtract to add
    assign n_merr = r2_neg ? MERR_BITS'(r2_tgt) + $signed(MERR_BITS'(r2_quot))
                           : MERR_BITS'(r2_tgt) - $signed(MERR_BITS'(r2_quot));
    assign n_mdiff = (MERR_BITS+1)'(n_merr) - (MERR_BITS+1)'(r_last_merr);
    assign n_msum  = (TOTAL_BITS+1)'(r_move_tot) + (TOTAL_BITS+1)'(n_merr);
    assign n_tdiff = (TERR_BITS+1)'(r2_terr) - (TERR_BITS+1)'(r_last_terr);
    assign n_tsum  = (TOTAL_BITS+1)'(r_turn_tot) + (TOTAL_BITS+1)'(r2_terr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_merr <= '0;
            r_move_tot  <= '0;
            r_last_terr <= '0;
            r_turn_tot  <= '0;
        end else if (upd) begin
            r_last_merr <= n_merr;
            r_move_tot  <= sat_total(n_msum);
            r_last_terr <= r2_terr;
            r_turn_tot  <= sat_total(n_tsum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_ERR]) begin
            r3_mdiff <= n_mdiff;
            r3_tdiff <= n_tdiff;
        end
    end

    // stages 4 to 6: the two loops
    t_loop_adv                    loop_adv;
    logic signed [POWER_BITS-1:0] move_power, turn_power;

    assign loop_adv.prod  = rdy[ST_PROD];
    assign loop_adv.acc   = rdy[ST_ACC];
    assign loop_adv.scale = rdy[ST_SCALE];

    dpid_loop #(
        .ERR_BITS (MERR_BITS),
        .SHIFT    (GAIN_FRAC_BITS)
    ) u_move_loop (
        .i_clk   (i_clk),
        .i_adv   (loop_adv),
        .i_kp    (r_move_kp),
        .i_kd    (r_move_kd),
        .i_ks    (r_move_ks),
        .i_err   (r_last_merr),
        .i_diff  (r3_mdiff),
        .i_tot   (r_move_tot),
        .o_power (move_power)
    );

    dpid_loop #(
        .ERR_BITS (TERR_BITS),
        .SHIFT    (GAIN_FRAC_BITS + HEADING_FRAC_BITS)
    ) u_turn_loop (
        .i_clk   (i_clk),
        .i_adv   (loop_adv),
        .i_kp    (r_turn_kp),
        .i_kd    (r_turn_kd),
        .i_ks    (r_turn_ks),
        .i_err   (r_last_terr),
        .i_diff  (r3_tdiff),
        .i_tot   (r_turn_tot),
        .o_power (turn_power)
    );

    // stage 7: side drives into the output register
    logic signed [POWER_BITS:0] left_sum, right_sum;
    t_dpid_out                  r_out;
    logic                       same_side;

    assign left_sum  = (POWER_BITS+1)'(move_power) + (POWER_BITS+1)'(turn_power);
    assign right_sum = (POWER_BITS+1)'(move_power) - (POWER_BITS+1)'(turn_power);

    always_ff @(posedge i_clk) begin
        if (rdy[ST_OUT]) begin
            r_out.left_drive  <= side_clamp(left_sum, r_limit);
            r_out.right_drive <= side_clamp(right_sum, r_limit);
            r_out.move_power  <= move_power;
            r_out.turn_power  <= turn_power;
        end
    end

    assign o_out     = r_out;
    assign same_side = (o_out.left_drive == o_out.right_drive);

    // an input transfer always lands in the first stage
    `DPID_ASSERT_NEXT(a_in_lands, i_clk, i_rst_n, i_in_valid && !o_in_stall, r_vld[ST_IN])
    // back-pressure reaches the input only with every stage full
    `DPID_ASSERT_NOW(a_stall_full, i_clk, i_rst_n, o_in_stall, (&r_vld) && i_out_stall)
    // loop state moves only when a valid item passes the error stage
    `DPID_ASSERT_NEXT(a_move_hold, i_clk, i_rst_n, !upd, $stable(r_move_tot) && $stable(r_last_merr))
    `DPID_ASSERT_NEXT(a_turn_hold, i_clk, i_rst_n, !upd, $stable(r_turn_tot) && $stable(r_last_terr))
    // with no turn command both sides drive the same
    `DPID_ASSERT_NOW(a_no_turn, i_clk, i_rst_n, o_out_valid && (o_out.turn_power == '0), same_side)

endmodule

### hw/rtl/dpid_loop.sv
// One PID loop datapath: gain products, wide sum, truncating scale, saturation.
// Depends on dpid_pkg; instantiated twice by dual_pid_drive_controller.
module dpid_loop
    import dpid_pkg::*;
#(
    parameter int ERR_BITS = 25,
    parameter int SHIFT    = 24
) (
    input  logic                         i_clk,
    input  t_loop_adv                    i_adv,
    input  logic        [GAIN_BITS-1:0]  i_kp,
    input  logic        [GAIN_BITS-1:0]  i_kd,
    input  logic        [GAIN_BITS-1:0]  i_ks,
    input  logic signed [ERR_BITS-1:0]   i_err,
    input  logic signed [ERR_BITS:0]     i_diff,
    input  logic signed [TOTAL_BITS-1:0] i_tot,
    output logic signed [POWER_BITS-1:0] o_power
);

    localparam int K_BITS      = GAIN_BITS + 1;
    localparam int TOT_LO_BITS = TOTAL_BITS / 2;
    localparam int TOT_HI_BITS = TOTAL_BITS - TOT_LO_BITS;
    localparam int PE_BITS     = K_BITS + ERR_BITS;
    localparam int PD_BITS     = K_BITS + ERR_BITS + 1;
    localparam int PL_BITS     = K_BITS + TOT_LO_BITS + 1;
    localparam int PH_BITS     = K_BITS + TOT_HI_BITS;
    localparam int ACC_BITS    = K_BITS + TOTAL_BITS + 1;

    localparam logic signed [ACC_BITS-1:0] BIAS =
        {{(ACC_BITS-SHIFT){1'b0}}, {SHIFT{1'b1}}};

    logic signed [K_BITS-1:0]   kp_s, kd_s, ks_s;
    logic signed [PE_BITS-1:0]  n_pe, r_pe;
    logic signed [PD_BITS-1:0]  n_pd, r_pd;
    logic signed [PL_BITS-1:0]  n_pl, r_pl;
    logic signed [PH_BITS-1:0]  n_ph, r_ph;
    logic signed [ACC_BITS-1:0] n_acc, r_acc;
    logic signed [ACC_BITS-1:0] biased, quot;
    logic                       pos_ovf, neg_ovf;
    logic signed [POWER_BITS-1:0] n_power, r_power;

    assign kp_s = {1'b0, i_kp};
    assign kd_s = {1'b0, i_kd};
    assign ks_s = {1'b0, i_ks};

    // split the 48-bit total into two halves to keep each multiply narrow
    assign n_pe = kp_s * i_err;
    assign n_pd = kd_s * i_diff;
    assign n_pl = ks_s * $signed({1'b0, i_tot[TOT_LO_BITS-1:0]});
    assign n_ph = ks_s * $signed(i_tot[TOTAL_BITS-1:TOT_LO_BITS]);

    assign n_acc = ACC_BITS'(r_pe) + ACC_BITS'(r_pd) + ACC_BITS'(r_pl)
                 + (ACC_BITS'(r_ph) <<< TOT_LO_BITS);

    // round toward zero: bias negatives before the arithmetic shift
    assign biased  = r_acc + (r_acc[ACC_BITS-1] ? BIAS : '0);
    assign quot    = biased >>> SHIFT;
    assign pos_ovf = !quot[ACC_BITS-1] && (|quot[ACC_BITS-2:POWER_BITS-1]);
    assign neg_ovf = quot[ACC_BITS-1] && !(&quot[ACC_BITS-2:POWER_BITS-1]);

    always_comb begin
        if (pos_ovf) begin
            n_power = {1'b0, {(POWER_BITS-1){1'b1}}};
        end else if (neg_ovf) begin
            n_power = {1'b1, {(POWER_BITS-1){1'b0}}};
        end else begin
            n_power = quot[POWER_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv.prod) begin
            r_pe <= n_pe;
            r_pd <= n_pd;
            r_pl <= n_pl;
            r_ph <= n_ph;
        end
        if (i_adv.acc) begin
            r_acc <= n_acc;
        end
        if (i_adv.scale) begin
            r_power <= n_power;
        end
    end

    assign o_power = r_power;

endmodule

### bench/dual_pid_drive_controller_tb.sv
// Self-checking bench for dual_pid_drive_controller: random and directed samples,
// gain and limit reprogramming, and an exact-width predictor of both PID loops.
// Depends on dpid_pkg and the dual_pid_drive_controller RTL.
module dual_pid_drive_controller_tb
    import dpid_pkg::*;
();

    localparam int GAIN_FRAC    = 24;
    localparam int PIPE_LATENCY = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 204;
    localparam int PHASE_COUNT  = 9;

    localparam int POS_MAX  = (1 << (POSITION_BITS - 1)) - 1;
    localparam int POS_MIN  = -POS_MAX - 1;
    localparam int HEAD_MAX = (1 << (HEADING_BITS - 1)) - 1;
    localparam int HEAD_MIN = -HEAD_MAX - 1;
    localparam int TH_MAX   = (1 << (TARGET_HEADING_BITS - 1)) - 1;
    localparam int TH_MIN   = -TH_MAX - 1;

    localparam longint TOTAL_HI = (longint'(1) <<< (TOTAL_BITS - 1)) - 1;
    localparam longint TOTAL_LO = -TOTAL_HI - 1;
    localparam longint DRIVE_LO = -(longint'(1) <<< (DRIVE_BITS - 1));
    localparam longint POWER_HI = (longint'(1) <<< (POWER_BITS - 1)) - 1;
    localparam longint POWER_LO = -POWER_HI - 1;
    localparam logic signed [127:0] WIDE_HI = 128'sd2147483647;
    localparam logic signed [127:0] WIDE_LO = -128'sd2147483648;

    class drive_scoreboard;
        logic [GAIN_BITS-1:0]  move_kp, move_kd, move_ks;
        logic [GAIN_BITS-1:0]  turn_kp, turn_kd, turn_ks;
        logic [LIMIT_BITS-1:0] drive_limit;
        longint                last_move_err, move_err_total;
        longint                last_turn_err, turn_err_total;
        t_dpid_out             expected_drive[$];
        int                    checked;
        int                    mismatches;

        function new();
            move_kp        = RST_MOVE_KP;
            move_kd        = RST_MOVE_KD;
            move_ks        = RST_MOVE_KS;
            turn_kp        = RST_TURN_KP;
            turn_kd        = RST_TURN_KD;
            turn_ks        = RST_TURN_KS;
            drive_limit    = RST_LIMIT;
            last_move_err  = 0;
            move_err_total = 0;
            last_turn_err  = 0;
            turn_err_total = 0;
            checked        = 0;
            mismatches     = 0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                              input logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_MOVE_KP: move_kp = data;
                CFG_MOVE_KD: move_kd = data;
                CFG_MOVE_KS: move_ks = data;
                CFG_TURN_KP: turn_kp = data;
                CFG_TURN_KD: turn_kd = data;
                CFG_TURN_KS: turn_ks = data;
                CFG_LIMIT:   drive_limit = data[LIMIT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction

        function longint clamp_total(input longint t);
            if (t > TOTAL_HI) return TOTAL_HI;
            if (t < TOTAL_LO) return TOTAL_LO;
            return t;
        endfunction

        // exact sum of the three gain products, then truncate toward zero and saturate
        function longint loop_power(input logic [GAIN_BITS-1:0] kp, kd, ks,
                                    input longint err, prev, total, input int shift);
            logic signed [127:0] acc, divisor, quot;
            acc = $signed({96'd0, kp}) * 128'(err)
                + $signed({96'd0, kd}) * 128'(err - prev)
                + $signed({96'd0, ks}) * 128'(total);
            divisor = 128'sd1 <<< shift;
            quot = acc / divisor;
            if (quot > WIDE_HI) return POWER_HI;
            if (quot < WIDE_LO) return POWER_LO;
            return longint'(quot);
        endfunction

        function logic signed [DRIVE_BITS-1:0] side_drive(input longint v);
            if (v > longint'(drive_limit)) v = longint'(drive_limit);
            if (v < DRIVE_LO) v = DRIVE_LO;
            return DRIVE_BITS'(v);
        endfunction

        function void note_input(input t_dpid_in x);
            longint    wheel_sum, dist_now, move_err, turn_err, move_pow, turn_pow;
            t_dpid_out r;
            wheel_sum = longint'($signed(x.wheel_left_front)) + longint'($signed(x.wheel_left_mid))
                      + longint'($signed(x.wheel_left_back)) + longint'($signed(x.wheel_right_front))
                      + longint'($signed(x.wheel_right_mid)) + longint'($signed(x.wheel_right_back));
            dist_now = wheel_sum / WHEEL_COUNT;
            move_err = longint'($signed(x.target_distance)) - dist_now;
            move_err_total = clamp_total(move_err_total + move_err);
            move_pow = loop_power(move_kp, move_kd, move_ks, move_err, last_move_err,
                                  move_err_total, GAIN_FRAC);
            turn_err = longint'($signed(x.target_heading)) * (longint'(1) <<< HEADING_FRAC_BITS)
                     - longint'($signed(x.heading_now));
            turn_err_total = clamp_total(turn_err_total + turn_err);
            turn_pow = loop_power(turn_kp, turn_kd, turn_ks, turn_err, last_turn_err,
                                  turn_err_total, GAIN_FRAC + HEADING_FRAC_BITS);
            last_move_err = move_err;
            last_turn_err = turn_err;
            r.left_drive  = side_drive(move_pow + turn_pow);
            r.right_drive = side_drive(move_pow - turn_pow);
            r.move_power  = POWER_BITS'(move_pow);
            r.turn_power  = POWER_BITS'(turn_pow);
            expected_drive.push_back(r);
        endfunction

        task flag_mismatch(input string what);
            mismatches++;
            $display("mismatch %0d: %s", mismatches, what);
        endtask

        task compare_field(input string name, input logic signed [63:0] got,
                           input logic signed [63:0] want);
            if (got !== want)
                flag_mismatch($sformatf("tick %0d %s: got %0d, expected %0d",
                                        checked, name, got, want));
        endtask

        task check_result(input t_dpid_out got);
            t_dpid_out want;
            if (expected_drive.size() == 0) begin
                flag_mismatch("drive result with no sample waiting");
            end else begin
                want = expected_drive.pop_front();
                checked++;
                compare_field("left_drive", got.left_drive, want.left_drive);
                compare_field("right_drive", got.right_drive, want.right_drive);
                compare_field("move_power", got.move_power, want.move_power);
                compare_field("turn_power", got.turn_power, want.turn_power);
            end
        endtask
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      o_in_stall;
    t_dpid_in                  i_in        = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    t_dpid_out                 o_out;
    logic                      i_cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = CFG_MOVE_KP;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data  = '0;

    drive_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req      = 1'b0;
    bit hold_ack      = 1'b0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int settings_used = 0;
    int run_left      = 0;
    int run_goal, run_head, run_dist_off, run_head_off;

    dual_pid_drive_controller #(
        .GAIN_FRAC_BITS(GAIN_FRAC)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // receiver: check each output transfer, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(o_out);
        if (hold_req != hold_ack) begin
            hold_ack    <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int wobble(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_dpid_in make_item(input int lf, lm, lb, rf, rm, rb,
                                           input int hd, td, th);
        t_dpid_in x;
        x.wheel_left_front  = POSITION_BITS'(lf);
        x.wheel_left_mid    = POSITION_BITS'(lm);
        x.wheel_left_back   = POSITION_BITS'(lb);
        x.wheel_right_front = POSITION_BITS'(rf);
        x.wheel_right_mid   = POSITION_BITS'(rm);
        x.wheel_right_back  = POSITION_BITS'(rb);
        x.heading_now       = HEADING_BITS'(hd);
        x.target_distance   = POSITION_BITS'(td);
        x.target_heading    = TARGET_HEADING_BITS'(th);
        return x;
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task automatic load_settings(input logic [CFG_DATA_BITS-1:0] mkp, mkd, mks,
                                 input logic [CFG_DATA_BITS-1:0] tkp, tkd, tks, lim);
        write_reg(CFG_MOVE_KP, mkp);
        write_reg(CFG_MOVE_KD, mkd);
        write_reg(CFG_MOVE_KS, mks);
        write_reg(CFG_TURN_KP, tkp);
        write_reg(CFG_TURN_KD, tkd);
        write_reg(CFG_TURN_KS, tks);
        write_reg(CFG_LIMIT, lim);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // offer one sample after a random gap; return at the transfer edge
    task automatic send_item(input t_dpid_in item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            i_in       <= ~item;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(item);
    endtask

    // wait for every outstanding result, then let the pipeline go quiet
    task automatic settle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_dpid_in item;
        int       phase;
        int       n;
        sb = new();
        repeat (3) @(posedge i_clk);
        i_rst_n       <= 1'b1;
        send_idle_pct <= 33;
        recv_idle_pct <= 85;

        // directed samples under reset gains
        send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                            HEAD_MAX, POS_MAX, TH_MAX));
        send_item(make_item(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN,
                            HEAD_MIN, POS_MIN, TH_MIN));
        send_item(make_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                            0, POS_MIN, 0));
        send_item(make_item(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN,
                            0, POS_MAX, 0));
        // negative wheel sums must round toward zero
        send_item(make_item(-1, 0, 0, 0, 0, 0, 0, 0, 0));
        send_item(make_item(-7, 0, 0, 0, 0, 0, 1, 0, 0));
        send_item(make_item(0, 0, 0, 0, 0, 0, HEAD_MIN, 0, TH_MAX));
        send_item(make_item(0, 0, 0, 0, 0, 0, HEAD_MAX, 0, TH_MIN));
        send_item(make_item(100, 102, 98, 101, 99, 100, 1600, 140, 101));
        send_item(make_item(-500, -505, -495, -500, -498, -502, -3205, -520, -200));
        send_item(make_item(7, 7, 7, 7, 7, 7, 16, 7, 1));
        i_in_valid <= 1'b0;
        settle();

        // full-scale gains drive both loops into saturation and limit above hundred
        load_settings('1, '1, '1, '1, '1, '1, '1);
        send_item(make_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                            HEAD_MAX, POS_MAX, TH_MAX));
        send_item(make_item(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN,
                            HEAD_MIN, POS_MIN, TH_MIN));
        send_item(make_item(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX,
                            0, POS_MIN, 0));
        send_item(make_item(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN,
                            0, POS_MAX, 0));
        send_item(make_item(0, 0, 0, 0, 0, 0, HEAD_MIN, 0, TH_MAX));
        send_item(make_item(0, 0, 0, 0, 0, 0, HEAD_MAX, 0, TH_MIN));
        i_in_valid <= 1'b0;
        settle();

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase / 3)
                0: begin
                    send_idle_pct <= 33;
                    recv_idle_pct <= 85;
                end
                1: begin
                    send_idle_pct <= 85;
                    recv_idle_pct <= 33;
                end
                default: begin
                    send_idle_pct <= 0;
                    recv_idle_pct <= 0;
                end
            endcase
            case (phase)
                0: load_settings(RST_MOVE_KP, $urandom_range(0, 32'h00FF_FFFF), RST_MOVE_KS,
                                 RST_TURN_KP, $urandom_range(0, 32'h00FF_FFFF), RST_TURN_KS,
                                 32'd100);
                1: load_settings('0, '0, '0, '0, '0, '0, '0);
                2: load_settings('1, '1, '1, '1, '1, '1, '1);
                4: load_settings($urandom, $urandom_range(0, 1 << 22), $urandom_range(0, 1 << 22),
                                 $urandom, $urandom_range(0, 1 << 22), $urandom_range(0, 1 << 22),
                                 32'd127);
                6: load_settings(RST_MOVE_KP, RST_MOVE_KD, RST_MOVE_KS, RST_TURN_KP,
                                 RST_TURN_KD, RST_TURN_KS, {25'($urandom), RST_LIMIT});
                3, 7: load_settings($urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
                                    $urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
                                    $urandom_range(0, 1 << 26), $urandom_range(0, 1 << 26),
                                    $urandom);
                default: load_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom);
            endcase
            // block the output for a long stretch while samples keep coming
            if (phase == 6) hold_req <= ~hold_req;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 25) begin
                    item.wheel_left_front  = POSITION_BITS'($urandom);
                    item.wheel_left_mid    = POSITION_BITS'($urandom);
                    item.wheel_left_back   = POSITION_BITS'($urandom);
                    item.wheel_right_front = POSITION_BITS'($urandom);
                    item.wheel_right_mid   = POSITION_BITS'($urandom);
                    item.wheel_right_back  = POSITION_BITS'($urandom);
                    item.heading_now       = HEADING_BITS'($urandom);
                    item.target_distance   = POSITION_BITS'($urandom);
                    item.target_heading    = TARGET_HEADING_BITS'($urandom);
                end else begin
                    // approach run: the base closes in on a fixed goal over several ticks
                    if (run_left == 0) begin
                        run_left     = $urandom_range(6, 40);
                        run_goal     = int'($urandom_range(0, 16000000)) - 8000000;
                        run_head     = int'($urandom_range(0, 1040000)) - 520000;
                        run_dist_off = wobble(20000);
                        run_head_off = wobble(10000);
                    end
                    run_left--;
                    run_dist_off = run_dist_off * 3 / 4 + wobble(3);
                    run_head_off = run_head_off * 3 / 4 + wobble(3);
                    item = make_item(run_goal - run_dist_off + wobble(50),
                                     run_goal - run_dist_off + wobble(50),
                                     run_goal - run_dist_off + wobble(50),
                                     run_goal - run_dist_off + wobble(50),
                                     run_goal - run_dist_off + wobble(50),
                                     run_goal - run_dist_off + wobble(50),
                                     run_head * 16 - run_head_off + wobble(8),
                                     run_goal, run_head);
                end
                send_item(item);
            end
            i_in_valid <= 1'b0;
            settle();
        end

        $display("covered %0d control ticks over %0d gain and limit settings",
                 sb.checked, settings_used);
        $display("idle mixes 33/85, 85/33 and none, plus one %0d-cycle output hold",
                 HOLD_CYCLES);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
